>>> src/lcm_via_gcd_macros.svh
// ----------------------------------------------------------------------------
// lcm_via_gcd_macros.svh
// Assertion shorthands shared by the verification checkers of this block.
// ----------------------------------------------------------------------------
`ifndef LCM_VIA_GCD_MACROS_SVH
`define LCM_VIA_GCD_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define LCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define LCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lcm_pkg.sv
// ----------------------------------------------------------------------------
// lcm_pkg
// Types and constants shared by the LCM block, its divider and its checker.
// ----------------------------------------------------------------------------
package lcm_pkg;

  // Working width of operands, divisor and result
  localparam int unsigned DataWidth = 32;
  // Step counter width for DataWidth-step iterations
  localparam int unsigned CntWidth  = $clog2(DataWidth);

  typedef logic [DataWidth-1:0] word_t;
  typedef logic [CntWidth-1:0]  cnt_t;

  // Input transaction
  typedef struct packed {
    logic [31:0] first_operand;
    logic [31:0] second_operand;
  } in_t;

  // Output transaction
  typedef struct packed {
    logic [31:0] multiple;
    logic        overflow;
  } out_t;

  // Divider request and response
  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
    word_t remainder;
  } div_rsp_t;

endpackage

>>> src/lcm_via_gcd.sv
// ----------------------------------------------------------------------------
// lcm_via_gcd
// Least common multiple of two unsigned operands. Euclid's remainder loop
// finds the GCD on a shared bit-serial divider, the same divider forms
// first / gcd, and a shift-add multiplier forms the exact product with the
// second operand. Results wider than DataWidth saturate and flag overflow.
//
//   channel | signals                         | direction
//   --------+---------------------------------+----------
//   input   | in_valid_i, in_ready_o, in_data_i     | in
//   output  | out_valid_o, out_ready_i, out_data_o  | out
//
// One pair at a time: in_ready_o is high only when the sequencer is idle.
// A zero operand skips the divider and the multiplier: the sequencer goes
// straight to StDone and sets out_valid_o once the output is free.
// Reset clears the sequencer and output valid. The output register holds a
// stalled result while the next pair is computed.
// ----------------------------------------------------------------------------
module lcm_via_gcd (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  lcm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output lcm_pkg::out_t out_data_o
);
  import lcm_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StGcd  = 5'b00010,
    StQuo  = 5'b00100,
    StMul  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  cnt_t                   cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_data_q;
  word_t                  a_q, b_q, y_q;
  logic [2*DataWidth-1:0] acc_q;
  logic [DataWidth:0]     mul_sum;
  word_t                  in_a, in_b;
  logic                   in_hs, out_free, ovf;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  lcm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_a     = word_t'(in_data_i.first_operand);
  assign in_b     = word_t'(in_data_i.second_operand);
  assign in_hs    = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Shift-add step: add multiplicand into the high half when low bit set
  assign mul_sum = {1'b0, acc_q[2*DataWidth-1:DataWidth]}
                 + (acc_q[0] ? {1'b0, b_q} : '0);
  assign ovf     = |acc_q[2*DataWidth-1:DataWidth];

  // Sequencer and divider launch
  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    out_valid_d      = out_valid_q;
    div_req.start    = 1'b0;
    div_req.dividend = in_a;
    div_req.divisor  = in_b;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      StIdle: begin
        if (in_hs) begin
          if (in_a == '0 || in_b == '0) begin
            state_d = StDone;
          end else begin
            div_req.start = 1'b1;
            state_d       = StGcd;
          end
        end
      end
      StGcd: begin
        if (div_rsp.done) begin
          div_req.start = 1'b1;
          if (div_rsp.remainder == '0) begin
            // y_q is the GCD: now divide the first operand by it
            div_req.dividend = a_q;
            div_req.divisor  = y_q;
            state_d          = StQuo;
          end else begin
            div_req.dividend = y_q;
            div_req.divisor  = div_rsp.remainder;
          end
        end
      end
      StQuo: begin
        if (div_rsp.done) begin
          cnt_d   = cnt_t'(DataWidth - 1);
          state_d = StMul;
        end
      end
      StMul: begin
        cnt_d = cnt_q - cnt_t'(1);
        if (cnt_q == '0) state_d = StDone;
      end
      StDone: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Operand, remainder and product registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (in_hs) begin
          a_q   <= in_a;
          b_q   <= in_b;
          y_q   <= in_b;
          acc_q <= '0;
        end
      end
      StGcd: begin
        if (div_rsp.done && div_rsp.remainder != '0) y_q <= div_rsp.remainder;
      end
      StQuo: begin
        if (div_rsp.done) acc_q <= {{DataWidth{1'b0}}, div_rsp.quotient};
      end
      StMul: begin
        acc_q <= {mul_sum, acc_q[DataWidth-1:1]};
      end
      StDone: begin
        if (out_free) begin
          out_data_q.multiple <= 32'(ovf ? {DataWidth{1'b1}} : acc_q[DataWidth-1:0]);
          out_data_q.overflow <= ovf;
        end
      end
      default: ;
    endcase
  end

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> src/lcm_div.sv
// ----------------------------------------------------------------------------
// lcm_div
// Restoring radix-2 divider: one quotient bit per cycle, DataWidth steps.
// Gives quotient and remainder with a one-cycle done pulse. The divisor must
// be nonzero; start is only honored while the unit is not busy.
// ----------------------------------------------------------------------------
module lcm_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lcm_pkg::div_req_t req_i,
  output lcm_pkg::div_rsp_t rsp_o
);
  import lcm_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  cnt_t               cnt_q, cnt_d;
  word_t              rem_q, quo_q, dsr_q;
  logic [DataWidth:0] trial, diff;
  logic               fits;
  word_t              rem_d, quo_d;

  // One restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    trial = {rem_q, quo_q[DataWidth-1]};
    diff  = trial - {1'b0, dsr_q};
    fits  = ~diff[DataWidth];
    rem_d = fits ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
    quo_d = {quo_q[DataWidth-2:0], fits};
  end

  // Step control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (busy_q) begin
      cnt_d = cnt_q - cnt_t'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = cnt_t'(DataWidth - 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end else if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

endmodule

>>> src/lcm_via_gcd_chk.sv
// ----------------------------------------------------------------------------
// lcm_via_gcd_chk
// Port-level checker for the LCM block, bound to every instance of it.
// ----------------------------------------------------------------------------
`include "lcm_via_gcd_macros.svh"

module lcm_via_gcd_chk (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input lcm_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input lcm_pkg::out_t out_data_o
);
  import lcm_pkg::*;

  // A stalled result holds its value
  `LCM_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "stalled result changed")

  // Saturated results are all ones
  `LCM_ASSERT_IMP(a_ovf_sat, out_valid_o && out_data_o.overflow, out_data_o.multiple == '1, "overflow without saturation")

  // A zero multiple never carries the overflow flag
  `LCM_ASSERT_IMP(a_zero_no_ovf, out_valid_o && out_data_o.multiple == '0, !out_data_o.overflow, "zero result flagged overflow")

  // One pair at a time: busy right after an accepted transaction
  `LCM_ASSERT_NXT(a_one_at_a_time, in_valid_i && in_ready_o, !in_ready_o, "accepted back-to-back transactions")

endmodule

bind lcm_via_gcd lcm_via_gcd_chk u_lcm_chk (.*);
